/* rtl/mkd_pkg.sv */
package mkd_pkg;

    // matrix geometry
    localparam int ROWS = 4;
    localparam int COLS = 4;
    localparam int KEY_COUNT = (ROWS * COLS > 16) ? 16 : ROWS * COLS;

    // field widths
    localparam int SAMPLE_W   = 16;
    localparam int TIME_W     = 32;
    localparam int BOOT_W     = 16;
    localparam int DEBOUNCE_W = 8;
    localparam int INDEX_W    = 4;
    localparam int CHAR_W     = 7;
    localparam int CODE_W     = 5;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 2 * SAMPLE_W + TIME_W;
    localparam int OUT_DATA_W = 16;

    // reset values of the registers
    localparam logic [BOOT_W-1:0]     BOOT_HOLD_RESET = 16'd4000;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET  = 8'd40;

    // mask of the keys that exist in the matrix
    localparam logic [SAMPLE_W-1:0] KEY_MASK =
        (KEY_COUNT >= 16) ? 16'hFFFF : SAMPLE_W'((32'd1 << KEY_COUNT) - 32'd1);

    // register indexes of the configuration port
    typedef enum logic [0:0] {
        CFG_BOOT_HOLD = 1'b0,
        CFG_DEBOUNCE  = 1'b1
    } cfg_reg_t;

    // ascii code of a key, zero for a key outside the 4x4 legend
    function automatic logic [CHAR_W-1:0] key_char_of(input logic [INDEX_W-1:0] idx);
        logic [INDEX_W-1:0] r;
        logic [INDEX_W-1:0] c;
        logic [CHAR_W-1:0]  ch;
        r  = INDEX_W'(idx / COLS);
        c  = INDEX_W'(idx % COLS);
        ch = '0;
        if (r < 4'd4 && c < 4'd4)
        begin
            case ({r[1:0], c[1:0]})
                4'h0:    ch = 7'h31;  // 1
                4'h1:    ch = 7'h32;  // 2
                4'h2:    ch = 7'h33;  // 3
                4'h3:    ch = 7'h41;  // A
                4'h4:    ch = 7'h34;  // 4
                4'h5:    ch = 7'h35;  // 5
                4'h6:    ch = 7'h36;  // 6
                4'h7:    ch = 7'h42;  // B
                4'h8:    ch = 7'h37;  // 7
                4'h9:    ch = 7'h38;  // 8
                4'hA:    ch = 7'h39;  // 9
                4'hB:    ch = 7'h43;  // C
                4'hC:    ch = 7'h2A;  // *
                4'hD:    ch = 7'h30;  // 0
                4'hE:    ch = 7'h23;  // #
                4'hF:    ch = 7'h44;  // D
                default: ch = '0;
            endcase
        end
        return ch;
    endfunction

endpackage

/* rtl/matrix_keypad_debouncer_unit.sv */
// Keypad debouncer for a 4x4 key matrix. Each input item is one poll: two closure
// samples and the current millisecond time; each poll yields exactly one result item,
// which carries a key only when a debounced new press is reported. An item is taken
// into an input register, checked combinationally against the key state, and lands in
// an output register, so one item per clock is sustained while the sink takes results.
// The output register holds a result while the sink stalls, and a new item is still taken
// as long as the input register can move.
// During the boot hold (now_ms below boot_hold_ms) nothing is reported; after that a
// key must be the highest closed key for debounce_ms before it is reported, once,
// until all keys are released.
module matrix_keypad_debouncer_unit
    import mkd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // polls in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // first_read, second_read, now_ms
    // results out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // key_valid, key_index, key_char, zero pad
);

    logic [BOOT_W-1:0]     boot_hold_reg;
    logic [DEBOUNCE_W-1:0] debounce_reg;

    logic                  in_valid_reg;
    logic [SAMPLE_W-1:0]   first_read_reg;
    logic [SAMPLE_W-1:0]   second_read_reg;
    logic [TIME_W-1:0]     now_ms_reg;

    logic [CODE_W-1:0]     stable_key_reg;
    logic [CODE_W-1:0]     stable_key_next;
    logic [CODE_W-1:0]     reported_key_reg;
    logic [CODE_W-1:0]     reported_key_next;
    logic [TIME_W-1:0]     change_time_reg;
    logic [TIME_W-1:0]     change_time_next;

    logic                  out_valid_reg;
    logic                  key_valid_reg;
    logic                  key_valid_next;
    logic [INDEX_W-1:0]    key_index_reg;
    logic [INDEX_W-1:0]    key_index_next;
    logic [CHAR_W-1:0]     key_char_reg;
    logic [CHAR_W-1:0]     key_char_next;

    logic                  advance;
    logic [SAMPLE_W-1:0]   closed;
    logic [CODE_W-1:0]     code;
    logic [TIME_W-1:0]     elapsed;

    // handshake: input register moves when the output register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - 1 - INDEX_W - CHAR_W){1'b0}},
                       key_char_reg, key_index_reg, key_valid_reg};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_hold_reg <= BOOT_HOLD_RESET;
            debounce_reg  <= DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_BOOT_HOLD: boot_hold_reg <= cfg_data[BOOT_W-1:0];
                CFG_DEBOUNCE:  debounce_reg  <= cfg_data[DEBOUNCE_W-1:0];
                default:       ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            first_read_reg  <= s_tdata[SAMPLE_W-1:0];
            second_read_reg <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
            now_ms_reg      <= s_tdata[IN_DATA_W-1:2*SAMPLE_W];
        end
    end

    // highest closed key, as index + 1
    assign closed  = first_read_reg & second_read_reg & KEY_MASK;
    assign elapsed = now_ms_reg - change_time_reg;

    always_comb
    begin
        code = '0;
        for (int i = 0; i < SAMPLE_W; i++)
        begin
            if (closed[i])
            begin
                code = CODE_W'(i + 1);
            end
        end
    end

    // debounce decision and next key state
    always_comb
    begin
        stable_key_next   = stable_key_reg;
        reported_key_next = reported_key_reg;
        change_time_next  = change_time_reg;
        key_valid_next    = 1'b0;
        key_index_next    = '0;
        key_char_next     = '0;
        if (now_ms_reg < {{(TIME_W - BOOT_W){1'b0}}, boot_hold_reg} || code == '0)
        begin
            stable_key_next   = '0;
            reported_key_next = '0;
        end
        else if (code != stable_key_reg)
        begin
            stable_key_next  = code;
            change_time_next = now_ms_reg;
        end
        else if (elapsed >= {{(TIME_W - DEBOUNCE_W){1'b0}}, debounce_reg} &&
                 code != reported_key_reg)
        begin
            reported_key_next = code;
            key_valid_next    = 1'b1;
            key_index_next    = INDEX_W'(code - 5'd1);
            key_char_next     = key_char_of(INDEX_W'(code - 5'd1));
        end
    end

    // key state, updated once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_key_reg   <= '0;
            reported_key_reg <= '0;
            change_time_reg  <= '0;
        end
        else if (advance)
        begin
            stable_key_reg   <= stable_key_next;
            reported_key_reg <= reported_key_next;
            change_time_reg  <= change_time_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            key_valid_reg <= key_valid_next;
            key_index_reg <= key_index_next;
            key_char_reg  <= key_char_next;
        end
    end

    // a reported key of the 4x4 matrix always has a legend
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && key_valid_reg) |-> (key_char_reg != '0))
    else $error("reported key has no character");

    // a result without a key carries zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !key_valid_reg) |-> (key_index_reg == '0 && key_char_reg == '0))
    else $error("empty result carries key data");

    // a result appears only from a held item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(in_valid_reg))
    else $error("result without an item");

    // input stalls only when both registers are full and the sink stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
    else $error("input stalled without cause");

    // the state never holds a reported key while no key is stable
    assert property (@(posedge clk) disable iff (!rst_n)
        (stable_key_reg == '0) |-> (reported_key_reg == '0))
    else $error("reported key without a stable key");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import mkd_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_TICKS = 12;
    localparam int SETTLE_TICKS = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SHOW_LIMIT  = 10;

    // one poll of the matrix and one reported key; first_read sits in the lowest bits
    typedef struct packed {
        logic [TIME_W-1:0]   now_ms;
        logic [SAMPLE_W-1:0] second_read;
        logic [SAMPLE_W-1:0] first_read;
    } poll_t;

    typedef struct packed {
        logic               key_valid;
        logic [INDEX_W-1:0] key_index;
        logic [CHAR_W-1:0]  key_char;
    } key_report_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [0:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    matrix_keypad_debouncer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // polls waiting to be sent and reports waiting to come back
    poll_t       poll_q[$];
    key_report_t expected_reports[$];
    poll_t       next_poll;
    int          pending_polls = 0;
    int          send_idle_pct = 33;
    int          recv_stall_pct = 33;

    // debouncer state kept by the testbench
    logic [BOOT_W-1:0]     boot_hold_cfg = BOOT_HOLD_RESET;
    logic [DEBOUNCE_W-1:0] debounce_cfg  = DEBOUNCE_RESET;
    logic [CODE_W-1:0]     cand_code = '0;
    logic [CODE_W-1:0]     last_reported_code = '0;
    logic [TIME_W-1:0]     cand_since_ms = '0;

    // bookkeeping
    int errors = 0;
    int results_seen = 0;
    int reports_seen = 0;
    int polls_sent = 0;
    int cfg_writes = 0;
    int cycle_count = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ascii legend of the 4x4 pad
    function automatic logic [CHAR_W-1:0] legend_char(input logic [INDEX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "1";
            4'd1:    c = "2";
            4'd2:    c = "3";
            4'd3:    c = "A";
            4'd4:    c = "4";
            4'd5:    c = "5";
            4'd6:    c = "6";
            4'd7:    c = "B";
            4'd8:    c = "7";
            4'd9:    c = "8";
            4'd10:   c = "9";
            4'd11:   c = "C";
            4'd12:   c = "*";
            4'd13:   c = "0";
            4'd14:   c = "#";
            default: c = "D";
        endcase
        return c[CHAR_W-1:0];
    endfunction

    // advance the key state by one poll and return the report it yields
    function automatic key_report_t debounce_poll(input poll_t p);
        key_report_t        rep;
        logic [SAMPLE_W-1:0] closed;
        logic [CODE_W-1:0]   code;
        logic [TIME_W-1:0]   held_ms;
        rep    = '0;
        closed = p.first_read & p.second_read & KEY_MASK;
        code   = '0;
        for (int i = 0; i < SAMPLE_W; i++)
        begin
            if (closed[i])
                code = CODE_W'(i + 1);
        end
        held_ms = p.now_ms - cand_since_ms;
        if (p.now_ms < {{(TIME_W-BOOT_W){1'b0}}, boot_hold_cfg})
        begin
            cand_code          = '0;
            last_reported_code = '0;
        end
        else if (code == '0)
        begin
            cand_code          = '0;
            last_reported_code = '0;
        end
        else if (code != cand_code)
        begin
            cand_code     = code;
            cand_since_ms = p.now_ms;
        end
        else if (held_ms >= {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_cfg}
                 && code != last_reported_code)
        begin
            last_reported_code = code;
            rep.key_valid = 1'b1;
            rep.key_index = INDEX_W'(code - 1'b1);
            rep.key_char  = legend_char(INDEX_W'(code - 1'b1));
        end
        return rep;
    endfunction

    // poll driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_reports.push_back(debounce_poll(poll_t'(s_tdata)));
                pending_polls--;
                polls_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (poll_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_poll = poll_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_poll.now_ms, next_poll.second_read,
                                 next_poll.first_read};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                key_report_t want;
                key_report_t got;
                got.key_valid = m_tdata[0];
                got.key_index = m_tdata[INDEX_W:1];
                got.key_char  = m_tdata[INDEX_W+CHAR_W:INDEX_W+1];
                results_seen++;
                if (got.key_valid)
                    reports_seen++;
                if (expected_reports.size() == 0)
                begin
                    errors++;
                    if (errors <= SHOW_LIMIT)
                        $display("unexpected result item %0d: valid=%0d index=%0d char=%02h",
                                 results_seen, got.key_valid, got.key_index, got.key_char);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.key_valid !== want.key_valid || got.key_index !== want.key_index
                        || got.key_char !== want.key_char)
                    begin
                        errors++;
                        if (errors <= SHOW_LIMIT)
                            $display({"mismatch on result item %0d: expected valid=%0d ",
                                      "index=%0d char=%02h, got valid=%0d index=%0d char=%02h"},
                                     results_seen, want.key_valid, want.key_index,
                                     want.key_char, got.key_valid, got.key_index, got.key_char);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_reports.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic queue_poll(input logic [SAMPLE_W-1:0] f, input logic [SAMPLE_W-1:0] s,
                              input logic [TIME_W-1:0] t);
        poll_t p;
        p.first_read  = f;
        p.second_read = s;
        p.now_ms      = t;
        poll_q.push_back(p);
        pending_polls++;
    endtask

    // wait until every poll is sent and every result is back
    task automatic wait_drained();
        @(posedge clk);
        while (pending_polls != 0 || expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_BOOT_HOLD)
            boot_hold_cfg = value[BOOT_W-1:0];
        else
            debounce_cfg = value[DEBOUNCE_W-1:0];
        cfg_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly key press runs with bounce, plus releases and random noise
    task automatic queue_random_polls(input int count, inout logic [TIME_W-1:0] t);
        int                  queued;
        int                  kind;
        int                  run_len;
        int                  step_max;
        int                  k;
        logic [SAMPLE_W-1:0] key_bit;
        logic [SAMPLE_W-1:0] f;
        logic [SAMPLE_W-1:0] s;
        queued   = 0;
        step_max = int'(debounce_cfg) / 4 + 2;
        while (queued < count)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                k       = $urandom_range(15);
                run_len = $urandom_range(12, 2);
                for (int i = 0; i < run_len && queued < count; i++)
                begin
                    // occasionally a different key takes over mid-run
                    if ($urandom_range(9) == 0)
                        k = $urandom_range(15);
                    key_bit = SAMPLE_W'(1) << k;
                    f = key_bit | (SAMPLE_W'($urandom) & (key_bit - 1'b1));
                    s = key_bit | (SAMPLE_W'($urandom) & (key_bit - 1'b1));
                    // contact bounce in one sample
                    if ($urandom_range(9) == 0)
                    begin
                        if ($urandom_range(1))
                            f = f & ~key_bit;
                        else
                            s = s & ~key_bit;
                    end
                    t += TIME_W'($urandom_range(step_max));
                    queue_poll(f, s, t);
                    queued++;
                end
                // release: the samples never agree on a key
                if (queued < count)
                begin
                    f = SAMPLE_W'($urandom);
                    t += TIME_W'($urandom_range(step_max));
                    queue_poll(f, ~f, t);
                    queued++;
                end
            end
            else if (kind < 85)
            begin
                if ($urandom_range(4) == 0)
                    t = $urandom;
                else
                    t += TIME_W'($urandom_range(step_max));
                queue_poll(SAMPLE_W'($urandom), SAMPLE_W'($urandom), t);
                queued++;
            end
            else
            begin
                t += TIME_W'($urandom_range(step_max));
                queue_poll('0, '0, t);
                queued++;
            end
        end
    endtask

    // stimulus
    initial
    begin
        logic [TIME_W-1:0] t;

        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: boot hold, debounce, reporting once, return to a reported key
        queue_poll(16'hFFFF, 16'hFFFF, 32'd0);
        queue_poll(16'h8000, 16'h8000, 32'd3999);
        queue_poll(16'hFFFF, 16'h8000, 32'd4000);
        queue_poll(16'h8000, 16'hFFFF, 32'd4039);
        queue_poll(16'h8000, 16'h8000, 32'd4040);
        queue_poll(16'h8000, 16'h8000, 32'd4100);
        queue_poll(16'h0001, 16'h0000, 32'd4101);
        queue_poll(16'h0001, 16'h0001, 32'd4200);
        queue_poll(16'h0001, 16'h0001, 32'd4240);
        queue_poll(16'h0021, 16'h0021, 32'd4241);
        queue_poll(16'h0001, 16'h0001, 32'd4250);
        queue_poll(16'h0001, 16'h0001, 32'd4300);
        queue_poll(16'h0021, 16'h0021, 32'd4301);
        queue_poll(16'h0021, 16'h0021, 32'd4341);
        queue_poll(16'h0000, 16'h0000, 32'd4400);
        wait_drained();

        // zero boot hold and zero debounce: report on the second poll
        write_cfg(CFG_BOOT_HOLD, 16'd0);
        write_cfg(CFG_DEBOUNCE, 16'd0);
        queue_poll(16'h0008, 16'h0008, 32'd100);
        queue_poll(16'h0008, 16'h0008, 32'd100);
        queue_poll(16'h1000, 16'h1000, 32'hFFFF_FFFF);
        queue_poll(16'h1000, 16'h1000, 32'd0);
        wait_drained();

        // longest debounce across the time wrap
        write_cfg(CFG_DEBOUNCE, 16'hFFFF);
        queue_poll(16'h4000, 16'h4000, 32'hFFFF_FF80);
        queue_poll(16'h4000, 16'h4000, 32'h0000_007E);
        queue_poll(16'h4000, 16'h4000, 32'h0000_007F);
        queue_poll(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        wait_drained();

        // random runs over several settings
        write_cfg(CFG_BOOT_HOLD, 16'd2000);
        write_cfg(CFG_DEBOUNCE, 16'd40);
        t = 32'd1500;
        queue_random_polls(90, t);
        wait_drained();

        // no idling on either side for this stretch
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_cfg(CFG_BOOT_HOLD, 16'd0);
        write_cfg(CFG_DEBOUNCE, {8'($urandom), 8'd0});
        t = $urandom;
        queue_random_polls(60, t);
        wait_drained();
        send_idle_pct  = 33;
        recv_stall_pct = 33;

        write_cfg(CFG_BOOT_HOLD, 16'hFFFF);
        write_cfg(CFG_DEBOUNCE, 16'd255);
        t = 32'd65000;
        queue_random_polls(100, t);
        wait_drained();

        write_cfg(CFG_BOOT_HOLD, 16'($urandom_range(255)));
        write_cfg(CFG_DEBOUNCE, 16'($urandom));
        t = 32'hFFFF_F000;
        queue_random_polls(100, t);
        wait_drained();

        write_cfg(CFG_BOOT_HOLD, 16'd4000);
        write_cfg(CFG_DEBOUNCE, 16'd10);
        t = 32'd3900;
        queue_random_polls(100, t);
        wait_drained();

        errors += expected_reports.size();
        $display("run covered %0d polls and %0d results, %0d of them key reports,",
                 polls_sent, results_seen, reports_seen);
        $display("over %0d register writes spanning boot hold, debounce and time wrap",
                 cfg_writes);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
